// ----- hw/rtl/max_tracking_queue_defines.svh -----
// ----------------------------------------------------------------------------
// max_tracking_queue_defines
// Assertion macros shared by the max tracking queue RTL.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_QUEUE_DEFINES_SVH
`define MAX_TRACKING_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MTQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mtq assertion failed");
`define MTQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mtq assertion failed");
`else
`define MTQ_ASSERT(lbl, clk, rst, prop)
`define MTQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/mtq_pkg.sv -----
// ----------------------------------------------------------------------------
// mtq_pkg
// Types and constants for the max tracking queue.
// ----------------------------------------------------------------------------
package mtq_pkg;

  localparam int MTQ_STACK_DEPTH = 1024;
  localparam int MTQ_DATA_W      = 64;

  localparam logic signed [MTQ_DATA_W-1:0] NEG_LIMIT = {1'b1, {(MTQ_DATA_W-1){1'b0}}};

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // one stack entry: value and running max of it and all entries below
  typedef struct packed {
    logic signed [MTQ_DATA_W-1:0] value;
    logic signed [MTQ_DATA_W-1:0] maxv;
  } mtq_entry_t;

endpackage

// ----- hw/rtl/mtq_ram.sv -----
// ----------------------------------------------------------------------------
// mtq_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mtq_max.sv -----
// ----------------------------------------------------------------------------
// mtq_max
// Shared signed maximum unit.
// ----------------------------------------------------------------------------
module mtq_max import mtq_pkg::*; (
  input  logic signed [MTQ_DATA_W-1:0] a,
  input  logic signed [MTQ_DATA_W-1:0] b,
  output logic signed [MTQ_DATA_W-1:0] y
);

  assign y = (a > b) ? a : b;

endmodule

// ----- hw/rtl/max_tracking_queue.sv -----
// ----------------------------------------------------------------------------
// max_tracking_queue
// FIFO of signed 64-bit values built from two stacks, reporting its maximum.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  command   start / busy        kind, data_in
//  result    done (strobe)       data_out, peak, is_empty, error_flag
//
//  Status, a rejected enqueue and a dequeue on an empty queue go from dispatch
//  to report; an enqueue passes the push state, a dequeue pop read, pop max
//  and, if any remain, a wait reloading the output stack's top max. An empty
//  output stack first takes the input stack over, one entry per cycle.
//  Stacks live in two RAMs; one shared max unit serves push, move and result.
//  Reset is synchronous and needs no clearing pass; done is never stalled.
// ----------------------------------------------------------------------------
`include "max_tracking_queue_defines.svh"

module max_tracking_queue import mtq_pkg::*; #(
  parameter int STACK_DEPTH = MTQ_STACK_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   kind,
  input  logic signed [MTQ_DATA_W-1:0] data_in,
  output logic                         busy,
  output logic                         done,
  output logic signed [MTQ_DATA_W-1:0] data_out,
  output logic signed [MTQ_DATA_W-1:0] peak,
  output logic                         is_empty,
  output logic [1:0]                   error_flag
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH,
    S_XFER_RD,
    S_XFER_WR,
    S_POP_RD,
    S_POP_MAX,
    S_POP_WAIT,
    S_REPORT
  } state_t;

  state_t                       state;
  logic [1:0]                   cmd_kind;
  logic signed [MTQ_DATA_W-1:0] cmd_data;
  logic [CW-1:0]                in_count;
  logic [CW-1:0]                out_count;
  logic signed [MTQ_DATA_W-1:0] in_top_max;
  logic signed [MTQ_DATA_W-1:0] out_top_max;
  logic signed [MTQ_DATA_W-1:0] pop_value;
  logic [1:0]                   err;

  logic [CW-1:0]                in_dec;
  logic [CW-1:0]                out_dec;
  logic signed [MTQ_DATA_W-1:0] alu_a;
  logic signed [MTQ_DATA_W-1:0] alu_b;
  logic signed [MTQ_DATA_W-1:0] alu_y;
  logic signed [MTQ_DATA_W-1:0] push_max;
  logic signed [MTQ_DATA_W-1:0] xfer_max;

  logic       in_we;
  logic       in_re;
  mtq_entry_t in_wdata;
  mtq_entry_t in_rd;
  logic       out_we;
  logic       out_re;
  mtq_entry_t out_wdata;
  mtq_entry_t out_rd;

  assign busy    = (state != S_IDLE);
  assign in_dec  = in_count - CW'(1);
  assign out_dec = out_count - CW'(1);

  always_comb begin
    case (state)
      S_PUSH: begin
        alu_a = cmd_data;
        alu_b = in_top_max;
      end
      S_XFER_WR: begin
        alu_a = in_rd.value;
        alu_b = out_top_max;
      end
      default: begin
        alu_a = (in_count != '0) ? in_top_max : NEG_LIMIT;
        alu_b = (out_count != '0) ? out_top_max : NEG_LIMIT;
      end
    endcase
  end

  mtq_max u_max (
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  assign push_max = (in_count == '0) ? cmd_data : alu_y;
  assign xfer_max = (out_count == '0) ? in_rd.value : alu_y;

  assign in_we          = (state == S_PUSH);
  assign in_wdata.value = cmd_data;
  assign in_wdata.maxv  = push_max;
  assign in_re          = (state == S_XFER_RD) || ((state == S_XFER_WR) && (in_count != '0));

  assign out_we          = (state == S_XFER_WR);
  assign out_wdata.value = in_rd.value;
  assign out_wdata.maxv  = xfer_max;
  assign out_re          = (state == S_POP_RD) || ((state == S_POP_MAX) && (out_count != '0));

  mtq_ram #(
    .WIDTH ($bits(mtq_entry_t)),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_count[AW-1:0]),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_dec[AW-1:0]),
    .rdata (in_rd)
  );

  mtq_ram #(
    .WIDTH ($bits(mtq_entry_t)),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_count[AW-1:0]),
    .wdata (out_wdata),
    .re    (out_re),
    .raddr (out_dec[AW-1:0]),
    .rdata (out_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_kind <= kind;
            cmd_data <= data_in;
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          pop_value <= '0;
          err       <= ERR_OK;
          if (cmd_kind == KIND_ENQUEUE) begin
            if (in_count == FULL) begin
              err   <= ERR_FULL;
              state <= S_REPORT;
            end else begin
              state <= S_PUSH;
            end
          end else if (cmd_kind == KIND_DEQUEUE) begin
            if (out_count != '0) begin
              state <= S_POP_RD;
            end else if (in_count != '0) begin
              state <= S_XFER_RD;
            end else begin
              err   <= ERR_EMPTY;
              state <= S_REPORT;
            end
          end else begin
            state <= S_REPORT;
          end
        end
        S_PUSH: begin
          in_top_max <= push_max;
          in_count   <= in_count + CW'(1);
          state      <= S_REPORT;
        end
        S_XFER_RD: begin
          in_count <= in_dec;
          state    <= S_XFER_WR;
        end
        S_XFER_WR: begin
          out_top_max <= xfer_max;
          out_count   <= out_count + CW'(1);
          if (in_count != '0) begin
            in_count <= in_dec;
          end else begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          out_count <= out_dec;
          state     <= S_POP_MAX;
        end
        S_POP_MAX: begin
          pop_value <= out_rd.value;
          state     <= (out_count != '0) ? S_POP_WAIT : S_REPORT;
        end
        S_POP_WAIT: begin
          out_top_max <= out_rd.maxv;
          state       <= S_REPORT;
        end
        S_REPORT: begin
          data_out   <= pop_value;
          peak       <= alu_y;
          is_empty   <= (in_count == '0) && (out_count == '0);
          error_flag <= err;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MTQ_ASSERT(a_done_single, clk, rst, done |=> !done)
  `MTQ_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `MTQ_ASSERT(a_in_bound, clk, rst, (in_count <= FULL) && (out_count <= FULL))
  `MTQ_ASSERT(a_move_into_empty, clk, rst, (state == S_XFER_RD) |-> (out_count == '0))
  `MTQ_ASSERT(a_empty_max, clk, rst, (done && is_empty) |-> (peak == NEG_LIMIT))

endmodule
